// ----- rtl/core/tgs_pkg.sv -----
`default_nettype none

package tgs_pkg;

    localparam int SCORE_W = 24;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 23;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 16;

    localparam int ERROR_LIMIT = 10000;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      is_false_detection;
        logic                      last;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] best_grid_index;
        logic [VALUE_W-1:0] best_threshold;
        logic [VALUE_W-1:0] peak_score;
        logic [COUNT_W-1:0] false_alarms;
        logic [COUNT_W-1:0] misses;
        logic               found_best;
        logic               item_overflow;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic sweep_init;
        logic read;
        logic eval;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic k_last;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tgs_ctrl.sv -----
`default_nettype none

module tgs_ctrl
    import tgs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    last,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_EVAL  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        cmd.sweep_init = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.read = 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.k_last ? S_DIV : S_SCAN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ----- rtl/core/tgs_dp.sv -----
`default_nettype none

module tgs_dp
    import tgs_pkg::*;
#(
    parameter int MAX_ITEMS  = 4096,
    parameter int GRID_STEPS = 100
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    input  wire in_word_t   detection,
    input  wire logic       cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    output status_t         status,
    output out_word_t       result
);

    localparam int AW       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int KW       = $clog2(GRID_STEPS);
    localparam int RHS_W    = KW + VALUE_W;
    localparam int LHS_W    = SCORE_W + KW + 1;
    localparam int ERR_W    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 2;
    localparam int MEM_W    = SCORE_W + 1;
    localparam int RECIP_SH = RHS_W + KW;
    localparam int RECIP_W  = RHS_W + 1;
    localparam int PROD_W   = RHS_W + RECIP_W;

    localparam longint RECIP_L =
        ((longint'(1) << RECIP_SH) + longint'(GRID_STEPS) - longint'(1)) / longint'(GRID_STEPS);

    localparam logic [CNT_W-1:0]        FULL_COUNT = CNT_W'(MAX_ITEMS);
    localparam logic signed [LHS_W-1:0] GMUL       = LHS_W'(GRID_STEPS);
    localparam logic [KW-1:0]           K_END      = KW'(GRID_STEPS - 1);
    localparam logic [ERR_W-1:0]        ERR_INIT   = ERR_W'(ERROR_LIMIT);
    localparam logic [RECIP_W-1:0]      RECIP      = RECIP_W'(RECIP_L);

    logic [MEM_W-1:0] mem [MAX_ITEMS];

    logic [CNT_W-1:0]   count_reg;
    logic [VALUE_W-1:0] peak_reg;
    logic               overflow_reg;
    logic [CFG_W-1:0]   abs_miss_reg;

    logic [CNT_W-1:0]   addr_reg;
    logic               rd_valid_reg;
    logic [MEM_W-1:0]   rd_data_reg;

    logic [KW-1:0]      k_reg;
    logic [RHS_W-1:0]   rhs_reg;
    logic [CNT_W-1:0]   fp_reg;
    logic [CNT_W-1:0]   miss_reg;

    logic [ERR_W-1:0]   min_err_reg;
    logic [KW-1:0]      best_k_reg;
    logic [CNT_W-1:0]   best_fp_reg;
    logic [CNT_W-1:0]   best_miss_reg;
    logic [RHS_W-1:0]   best_rhs_reg;
    logic               found_reg;

    logic                      room;
    logic signed [SCORE_W-1:0] rd_score;
    logic                      rd_label;
    logic signed [LHS_W-1:0]   lhs;
    logic signed [LHS_W-1:0]   rhs_ext;
    logic                      above;
    logic [ERR_W-1:0]          err;
    logic [PROD_W-1:0]         quot_prod;
    logic [KW+INDEX_W:0]       k_wide;
    logic [CNT_W+COUNT_W-1:0]  fp_wide;
    logic [CNT_W+COUNT_W-1:0]  miss_wide;

    assign room     = (count_reg != FULL_COUNT);
    assign rd_score = rd_data_reg[MEM_W-1:1];
    assign rd_label = rd_data_reg[0];
    assign lhs      = LHS_W'(rd_score) * GMUL;
    assign rhs_ext  = $signed(LHS_W'(rhs_reg));
    assign above    = (lhs > rhs_ext);
    assign err      = ERR_W'(fp_reg) + ERR_W'(miss_reg) + ERR_W'(abs_miss_reg);

    // winning k*peak over the grid size by reciprocal multiplication
    assign quot_prod = PROD_W'(best_rhs_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            mem[count_reg[AW-1:0]] <= {detection.score, detection.is_false_detection};
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            peak_reg      <= '0;
            overflow_reg  <= 1'b0;
            abs_miss_reg  <= '0;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            k_reg         <= '0;
            rhs_reg       <= '0;
            fp_reg        <= '0;
            miss_reg      <= '0;
            min_err_reg   <= ERR_INIT;
            best_k_reg    <= '0;
            best_fp_reg   <= '0;
            best_miss_reg <= '0;
            best_rhs_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.read;

            if (cfg_we)
            begin
                abs_miss_reg <= cfg_wdata;
            end

            if (cmd.load)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                    if (detection.score > $signed({1'b0, peak_reg}))
                    begin
                        peak_reg <= detection.score[VALUE_W-1:0];
                    end
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end

            if (cmd.sweep_init)
            begin
                addr_reg      <= '0;
                k_reg         <= '0;
                rhs_reg       <= '0;
                fp_reg        <= '0;
                miss_reg      <= '0;
                min_err_reg   <= ERR_INIT;
                best_k_reg    <= '0;
                best_fp_reg   <= '0;
                best_miss_reg <= '0;
                best_rhs_reg  <= '0;
                found_reg     <= 1'b0;
            end

            if (cmd.read)
            begin
                addr_reg <= addr_reg + 1'b1;
            end

            if (rd_valid_reg)
            begin
                if (above && rd_label)
                begin
                    fp_reg <= fp_reg + 1'b1;
                end
                else if (!above && !rd_label)
                begin
                    miss_reg <= miss_reg + 1'b1;
                end
            end

            if (cmd.eval)
            begin
                if (err < min_err_reg)
                begin
                    min_err_reg   <= err;
                    best_k_reg    <= k_reg;
                    best_fp_reg   <= fp_reg;
                    best_miss_reg <= miss_reg;
                    best_rhs_reg  <= rhs_reg;
                    found_reg     <= 1'b1;
                end
                k_reg    <= k_reg + 1'b1;
                rhs_reg  <= rhs_reg + RHS_W'(peak_reg);
                addr_reg <= '0;
                fp_reg   <= '0;
                miss_reg <= '0;
            end

            if (cmd.div_step)
            begin
                best_rhs_reg <= RHS_W'(quot_prod[PROD_W-1:RECIP_SH]);
            end

            if (cmd.finish)
            begin
                count_reg    <= '0;
                peak_reg     <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    assign status.scan_end = (addr_reg == count_reg);
    assign status.k_last   = (k_reg == K_END);

    assign k_wide    = (KW + INDEX_W + 1)'(best_k_reg);
    assign fp_wide   = (CNT_W + COUNT_W)'(best_fp_reg);
    assign miss_wide = (CNT_W + COUNT_W)'(best_miss_reg);

    assign result.best_grid_index = k_wide[INDEX_W-1:0];
    assign result.best_threshold  = best_rhs_reg[VALUE_W-1:0];
    assign result.peak_score      = peak_reg;
    assign result.false_alarms    = fp_wide[COUNT_W-1:0];
    assign result.misses          = miss_wide[COUNT_W-1:0];
    assign result.found_best      = found_reg;
    assign result.item_overflow   = overflow_reg;

endmodule

`default_nettype wire

// ----- rtl/core/threshold_grid_sweep.sv -----
`default_nettype none

// Detection threshold search. Detections are loaded one word per cycle while busy is low;
// a word with last set starts the sweep. The sweep reads the single-port store once per
// grid step; each step scans the stored items, drains the last read and evaluates the error.
// After the last step a reciprocal multiply gives the threshold, then done is raised; busy is
// high throughout. The result word is on result for the single cycle that done is high; the
// receiver cannot stall it. The store needs no clearing after reset. The user must write
// absolute_misses through cfg_we/cfg_wdata only while the block is idle (unenforced).
module threshold_grid_sweep
    import tgs_pkg::*;
#(
    parameter int MAX_ITEMS  = 4096,
    parameter int GRID_STEPS = 100
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire in_word_t         detection,
    output logic                  done,
    output out_word_t             result,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    tgs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (detection.last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tgs_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .GRID_STEPS (GRID_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .detection (detection),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire
